### sv/fsip_pkg.sv
// Shared types and constants for the integer format printer.
// Holds the controller/datapath command and status structures and the ASCII codes.
// Depends on nothing; every other file of the block imports it.
package fsip_pkg;

    localparam int BYTE_W   = 8;
    localparam int ARG_W    = 32;
    localparam int CSF_W    = 9;
    localparam int FW_W     = 6;
    localparam int DIG_N    = 10;
    localparam int DIG_W    = 4 * DIG_N;
    localparam int NDIG_W   = 4;
    localparam int REM_W    = 6;
    localparam int DD_BITS  = 4;
    localparam int DD_STEPS = ARG_W / DD_BITS;
    localparam int STEP_W   = $clog2(DD_STEPS);

    localparam logic [BYTE_W-1:0] ASC_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] ASC_PERCENT = 8'h25;
    localparam logic [BYTE_W-1:0] ASC_MINUS   = 8'h2d;
    localparam logic [BYTE_W-1:0] ASC_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] ASC_ONE     = 8'h31;
    localparam logic [BYTE_W-1:0] ASC_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] ASC_QUERY   = 8'h3f;
    localparam logic [BYTE_W-1:0] ASC_LOW_C   = 8'h63;
    localparam logic [BYTE_W-1:0] ASC_LOW_D   = 8'h64;
    localparam logic [BYTE_W-1:0] ASC_LOW_U   = 8'h75;
    localparam logic [BYTE_W-1:0] ASC_LOW_X   = 8'h78;

    localparam logic [BYTE_W-1:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // What the byte just taken asks for.
    typedef enum logic [2:0] {
        ACT_NONE = 3'd0,
        ACT_ONE  = 3'd1,
        ACT_DEC  = 3'd2,
        ACT_HEX  = 3'd3,
        ACT_CHR  = 3'd4
    } action_t;

    // Source of the character written to the output register.
    typedef enum logic [2:0] {
        SEL_SPACE = 3'd0,
        SEL_ZERO  = 3'd1,
        SEL_MINUS = 3'd2,
        SEL_TEXT  = 3'd3,
        SEL_ONE   = 3'd4
    } char_sel_t;

    typedef struct packed {
        logic      accept;
        logic      conv_step;
        logic      size;
        logic      emit;
        char_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    conv_done;
        logic    out_free;
        logic    final_char;
        logic    fill_nz;
        logic    pad_last;
        logic    pad_nz;
        logic    dig_last;
        logic    neg;
        logic    left_align;
        logic    zero_fill;
    } dp_status_t;

endpackage

### sv/fsip_ctrl.sv
// Controller of the integer format printer: one-hot state machine over the field segments.
// Drives the datapath by dp_cmd_t and reads back dp_status_t; depends on fsip_pkg.
module fsip_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output fsip_pkg::dp_cmd_t    cmd,
    input  fsip_pkg::dp_status_t status
);
    import fsip_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CONV  = 9'b000000010,
        S_SIZE  = 9'b000000100,
        S_LEAD  = 9'b000001000,
        S_SIGN  = 9'b000010000,
        S_ZPAD  = 9'b000100000,
        S_TEXT  = 9'b001000000,
        S_TRAIL = 9'b010000000,
        S_ONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.conv_step = 1'b0;
        cmd.size      = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_SPACE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    unique case (status.action)
                        ACT_ONE:          state_next = S_ONE;
                        ACT_DEC:          state_next = S_CONV;
                        ACT_HEX, ACT_CHR: state_next = S_SIZE;
                        default:          state_next = S_IDLE;
                    endcase
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (status.conv_done)
                begin
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.size = 1'b1;
                priority if (!status.left_align && !status.zero_fill && status.fill_nz)
                begin
                    state_next = S_LEAD;
                end
                else if (status.neg)
                begin
                    state_next = S_SIGN;
                end
                else if (!status.left_align && status.zero_fill && status.fill_nz)
                begin
                    state_next = S_ZPAD;
                end
                else
                begin
                    state_next = S_TEXT;
                end
            end
            S_LEAD:
            begin
                cmd.sel  = SEL_SPACE;
                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    priority if (status.final_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.pad_last)
                    begin
                        state_next = status.neg ? S_SIGN : S_TEXT;
                    end
                    else
                    begin
                        state_next = S_LEAD;
                    end
                end
            end
            S_SIGN:
            begin
                cmd.sel  = SEL_MINUS;
                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    priority if (status.final_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!status.left_align && status.zero_fill && status.pad_nz)
                    begin
                        state_next = S_ZPAD;
                    end
                    else
                    begin
                        state_next = S_TEXT;
                    end
                end
            end
            S_ZPAD:
            begin
                cmd.sel  = SEL_ZERO;
                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    priority if (status.final_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.pad_last)
                    begin
                        state_next = S_TEXT;
                    end
                    else
                    begin
                        state_next = S_ZPAD;
                    end
                end
            end
            S_TEXT:
            begin
                cmd.sel  = SEL_TEXT;
                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    priority if (status.final_char)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (status.dig_last)
                    begin
                        state_next = S_TRAIL;
                    end
                    else
                    begin
                        state_next = S_TEXT;
                    end
                end
            end
            S_TRAIL:
            begin
                cmd.sel  = SEL_SPACE;
                cmd.emit = status.out_free;
                if (cmd.emit && status.final_char)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ONE:
            begin
                cmd.sel  = SEL_ONE;
                cmd.emit = status.out_free;
                if (cmd.emit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("character written while the output register was occupied");

    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.action != ACT_NONE) |=> in_stall)
        else $error("input not held off after a byte that produces output");

    a_sign_only_negative: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIGN) |-> status.neg)
        else $error("minus sign segment entered for a non-negative value");
`endif

endmodule

### sv/fsip_datapath.sv
// Datapath of the integer format printer: parse state, binary-to-BCD converter,
// field sizing counters and the output register. Depends on fsip_pkg.
module fsip_datapath #(
    parameter int OUT_LIMIT = 511,
    parameter int MAX_WIDTH = 63
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [fsip_pkg::BYTE_W-1:0]         format_byte,
    input  logic [fsip_pkg::ARG_W-1:0]          argument_word,
    input  logic                                string_start,
    input  fsip_pkg::dp_cmd_t                   cmd,
    output fsip_pkg::dp_status_t                status,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [fsip_pkg::BYTE_W-1:0]         out_char,
    output logic                                last_of_run,
    output logic [fsip_pkg::CSF_W-1:0]          chars_so_far
);
    import fsip_pkg::*;

    localparam int CNT_RAW = $clog2(OUT_LIMIT + 1);
    localparam int CNT_W   = (CNT_RAW > CSF_W) ? CNT_RAW : CSF_W;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(OUT_LIMIT);
    localparam logic [9:0]       WSAT  = 10'(MAX_WIDTH);

    typedef enum logic [2:0] {
        PH_PLAIN = 3'b001,
        PH_FLAGS = 3'b010,
        PH_WIDTH = 3'b100
    } phase_t;

    // Parse and count state.
    phase_t             phase_reg, phase_next;
    logic               la_reg, la_next;
    logic               zf_reg, zf_next;
    logic [FW_W-1:0]    fw_reg, fw_next;
    logic [CNT_W-1:0]   count_reg, count_eff, count_inc;

    // Conversion and sizing.
    logic [ARG_W-1:0]   mag_reg;
    logic [DIG_W-1:0]   digit_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               neg_reg, chr_reg;
    logic [BYTE_W-1:0]  one_char_reg, arg_char_reg;
    logic [REM_W-1:0]   pad_cnt_reg, rem_cnt_reg;
    logic [NDIG_W-1:0]  dig_idx_reg;

    // Output register.
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic [CSF_W-1:0]   out_csf_reg;

    // Combinational helpers.
    action_t            action;
    logic [BYTE_W-1:0]  one_char;
    logic               is_digit, do_conv, neg_in;
    logic [ARG_W-1:0]   mag_in;
    logic [9:0]         wsum;
    logic [DIG_W-1:0]   bcd_t;
    logic [ARG_W-1:0]   mag_t;
    logic [NDIG_W-1:0]  ndig;
    logic [FW_W-1:0]    total;
    logic [3:0]         cur_nib;
    logic [BYTE_W-1:0]  char_mux;

    // Byte decode against the state as it stands after any string start clear.
    always_comb
    begin
        count_eff  = string_start ? '0 : count_reg;
        phase_next = string_start ? PH_PLAIN : phase_reg;
        la_next    = string_start ? 1'b0 : la_reg;
        zf_next    = string_start ? 1'b0 : zf_reg;
        fw_next    = string_start ? '0 : fw_reg;
        action     = ACT_NONE;
        one_char   = format_byte;
        do_conv    = 1'b0;
        is_digit   = (format_byte >= ASC_ZERO) && (format_byte <= ASC_NINE);
        wsum       = ({4'b0, fw_next} << 3) + ({4'b0, fw_next} << 1)
                   + {6'b0, format_byte[3:0]};
        if (count_eff < LIMIT)
        begin
            unique case (phase_next)
                PH_FLAGS:
                begin
                    priority if (format_byte == ASC_MINUS)
                    begin
                        la_next = 1'b1;
                    end
                    else if (format_byte == ASC_ZERO)
                    begin
                        zf_next = 1'b1;
                    end
                    else if ((format_byte >= ASC_ONE) && (format_byte <= ASC_NINE))
                    begin
                        fw_next    = {2'b0, format_byte[3:0]};
                        phase_next = PH_WIDTH;
                    end
                    else
                    begin
                        do_conv = 1'b1;
                    end
                end
                PH_WIDTH:
                begin
                    if (is_digit)
                    begin
                        fw_next = (wsum > WSAT) ? FW_W'(MAX_WIDTH) : wsum[FW_W-1:0];
                    end
                    else
                    begin
                        do_conv = 1'b1;
                    end
                end
                default:
                begin
                    if (format_byte == ASC_PERCENT)
                    begin
                        phase_next = PH_FLAGS;
                        la_next    = 1'b0;
                        zf_next    = 1'b0;
                        fw_next    = '0;
                    end
                    else
                    begin
                        phase_next = PH_PLAIN;
                        action     = ACT_ONE;
                    end
                end
            endcase
            if (do_conv)
            begin
                phase_next = PH_PLAIN;
                unique case (format_byte)
                    ASC_LOW_D, ASC_LOW_U: action = ACT_DEC;
                    ASC_LOW_X:            action = ACT_HEX;
                    ASC_LOW_C:            action = ACT_CHR;
                    ASC_PERCENT:
                    begin
                        action   = ACT_ONE;
                        one_char = ASC_PERCENT;
                    end
                    default:
                    begin
                        action   = ACT_ONE;
                        one_char = ASC_QUERY;
                    end
                endcase
            end
        end
    end

    // A negative %d converts its magnitude; the most negative value maps onto itself.
    assign neg_in = do_conv && (format_byte == ASC_LOW_D) && argument_word[ARG_W-1];
    assign mag_in = neg_in ? (~argument_word + ARG_W'(1)) : argument_word;

    // Shift-and-add-three conversion, DD_BITS binary bits per cycle.
    always_comb
    begin
        bcd_t = digit_reg;
        mag_t = mag_reg;
        for (int s = 0; s < DD_BITS; s++)
        begin
            for (int k = 0; k < DIG_N; k++)
            begin
                if (bcd_t[4*k +: 4] >= 4'd5)
                begin
                    bcd_t[4*k +: 4] = bcd_t[4*k +: 4] + 4'd3;
                end
            end
            {bcd_t, mag_t} = {bcd_t[DIG_W-2:0], mag_t, 1'b0};
        end
    end

    // Significant digit count and the text length including the sign.
    always_comb
    begin
        ndig = NDIG_W'(1);
        for (int k = 0; k < DIG_N; k++)
        begin
            if (digit_reg[4*k +: 4] != 4'd0)
            begin
                ndig = NDIG_W'(k + 1);
            end
        end
        if (chr_reg)
        begin
            ndig = NDIG_W'(1);
        end
        total = FW_W'(ndig) + FW_W'(neg_reg);
    end

    always_comb
    begin
        cur_nib = 4'd0;
        for (int k = 0; k < DIG_N; k++)
        begin
            if (dig_idx_reg == NDIG_W'(k))
            begin
                cur_nib = digit_reg[4*k +: 4];
            end
        end
        unique case (cmd.sel)
            SEL_SPACE: char_mux = ASC_SPACE;
            SEL_ZERO:  char_mux = ASC_ZERO;
            SEL_MINUS: char_mux = ASC_MINUS;
            SEL_TEXT:  char_mux = chr_reg ? arg_char_reg : HEX_CHARS[cur_nib];
            SEL_ONE:   char_mux = one_char_reg;
            default:   char_mux = ASC_QUERY;
        endcase
    end

    assign count_inc = count_reg + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PLAIN;
            la_reg        <= 1'b0;
            zf_reg        <= 1'b0;
            fw_reg        <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            pad_cnt_reg   <= '0;
            rem_cnt_reg   <= '0;
            dig_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                phase_reg   <= phase_next;
                la_reg      <= la_next;
                zf_reg      <= zf_next;
                fw_reg      <= fw_next;
                count_reg   <= count_eff;
                step_reg    <= '0;
                rem_cnt_reg <= REM_W'(1);
            end
            else if (cmd.conv_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            else if (cmd.size)
            begin
                dig_idx_reg <= ndig - NDIG_W'(1);
                if (fw_reg > total)
                begin
                    pad_cnt_reg <= fw_reg - total;
                    rem_cnt_reg <= fw_reg;
                end
                else
                begin
                    pad_cnt_reg <= '0;
                    rem_cnt_reg <= total;
                end
            end
            else if (cmd.emit)
            begin
                count_reg   <= count_inc;
                rem_cnt_reg <= rem_cnt_reg - REM_W'(1);
                if ((cmd.sel == SEL_SPACE) || (cmd.sel == SEL_ZERO))
                begin
                    pad_cnt_reg <= pad_cnt_reg - REM_W'(1);
                end
                if (cmd.sel == SEL_TEXT)
                begin
                    dig_idx_reg <= dig_idx_reg - NDIG_W'(1);
                end
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg      <= mag_in;
            neg_reg      <= neg_in;
            chr_reg      <= (action == ACT_CHR);
            one_char_reg <= one_char;
            arg_char_reg <= argument_word[BYTE_W-1:0];
            digit_reg    <= (action == ACT_HEX) ? {{(DIG_W-ARG_W){1'b0}}, argument_word} : '0;
        end
        else if (cmd.conv_step)
        begin
            digit_reg <= bcd_t;
            mag_reg   <= mag_t;
        end
        if (cmd.emit)
        begin
            out_char_reg <= char_mux;
            out_last_reg <= status.final_char;
            out_csf_reg  <= count_inc[CSF_W-1:0];
        end
    end

    assign status.action     = action;
    assign status.conv_done  = (step_reg == STEP_W'(DD_STEPS - 1));
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.final_char = (rem_cnt_reg == REM_W'(1)) || (count_inc == LIMIT);
    assign status.fill_nz    = (fw_reg > total);
    assign status.pad_last   = (pad_cnt_reg == REM_W'(1));
    assign status.pad_nz     = (pad_cnt_reg != '0);
    assign status.dig_last   = (dig_idx_reg == '0);
    assign status.neg        = neg_reg;
    assign status.left_align = la_reg;
    assign status.zero_fill  = zf_reg;

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last_of_run  = out_last_reg;
    assign chars_so_far = out_csf_reg;

`ifndef SYNTHESIS
    a_emit_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (count_reg < LIMIT))
        else $error("character written after the per-string limit was reached");

    a_emit_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (rem_cnt_reg != '0))
        else $error("character written with no characters left in the field");

    a_start_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && string_start) |=> (count_reg == '0))
        else $error("string start did not clear the character count");
`endif

endmodule

### sv/format_string_integer_printer_core.sv
// A plain byte, literal percent or unknown conversion passes through the S_ONE state into the output
// register. Flag and width bytes keep in_stall low; a byte that produces output holds in_stall until
// its last character is written. %d and %u go through the binary-to-BCD converter and a sizing step,
// then one character goes out per cycle while the output is not stalled; %x and %c skip the converter.
// Reset (rst_n, asynchronous, active low) clears parse state, count and the output valid.
// There is no clearing pass; the block can accept a beat as soon as reset is released.
module format_string_integer_printer_core #(
    parameter int OUT_LIMIT = 511,
    parameter int MAX_WIDTH = 63
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [fsip_pkg::BYTE_W-1:0] format_byte,
    input  logic [fsip_pkg::ARG_W-1:0]  argument_word,
    input  logic                        string_start,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [fsip_pkg::BYTE_W-1:0] out_char,
    output logic                        last_of_run,
    output logic [fsip_pkg::CSF_W-1:0]  chars_so_far
);
    import fsip_pkg::*;

    // The controller walks each field through its segments: leading spaces, sign,
    // zero padding, the digits or character, and trailing spaces. The datapath holds
    // the format parse state, converts the argument and counts what is left to send.
    dp_cmd_t    cmd;
    dp_status_t status;

    fsip_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    // The output register decouples the two sides: a new input beat is taken while
    // the last character of the previous one still waits to be collected.
    fsip_datapath #(
        .OUT_LIMIT (OUT_LIMIT),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .format_byte   (format_byte),
        .argument_word (argument_word),
        .string_start  (string_start),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .out_char      (out_char),
        .last_of_run   (last_of_run),
        .chars_so_far  (chars_so_far)
    );

endmodule
